>>> hw/rtl/sha512_hash_engine_top_macros.svh
// Assertion helpers used by the sequencer
`ifndef SHA512_HASH_ENGINE_TOP_MACROS_SVH
`define SHA512_HASH_ENGINE_TOP_MACROS_SVH

// Clocked check, off while reset is asserted
`define SHA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the following cycle
`define SHA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sha512he_pkg.sv
package sha512he_pkg;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned ROUNDS   = 80;
	localparam int unsigned BLK_W    = 16;
	localparam int unsigned HASH_N   = 8;
	localparam int unsigned TOTAL_W  = 61;

	typedef logic [WORD_W-1:0] word_t;

	// Source of the word shifted into the schedule
	typedef enum logic [1:0] {
		SEL_WORD = 2'd0,
		SEL_MARK = 2'd1,
		SEL_ZERO = 2'd2,
		SEL_LEN  = 2'd3
	} push_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      accept;
		logic      push;
		push_sel_t sel;
		logic      start;
		logic      round;
		logic [6:0] rnd;
		logic      add;
		logic [2:0] oidx;
		logic      finish;
	} dp_cmd_t;

	localparam word_t IV [HASH_N] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam word_t KTAB [ROUNDS] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

endpackage

>>> hw/rtl/sha512he_if.sv
// Message word channel
interface sha512he_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] message_word;
	logic [3:0]  valid_bytes;
	logic        last_word;
	modport source (output valid, message_word, valid_bytes, last_word, input ready);
	modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

// Digest word channel
interface sha512he_dig_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic        digest_last;
	modport source (output valid, digest_word, digest_last, input ready);
	modport sink (input valid, digest_word, digest_last, output ready);
endinterface

>>> hw/rtl/sha512he_dp.sv
module sha512he_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha512he_pkg::dp_cmd_t cmd,
	input  logic [63:0]           message_word,
	input  logic [3:0]            valid_bytes,
	input  logic                  last_word,
	output logic [63:0]           digest_word
);
	import sha512he_pkg::*;

	word_t        word_q;
	logic [2:0]   vb_q;
	logic         full_q;
	word_t        w_q [BLK_W];
	word_t        v_q [HASH_N];
	word_t        h_q [HASH_N];
	logic [TOTAL_W-1:0] total_q;

	logic [3:0]   add_bytes;
	word_t        mark_word, push_word, new_w;
	word_t        s0, s1, big0, big1, ch, maj, t1, t2;
	logic [5:0]   mark_sh;

	// Bytes counted for this transaction; a non-last word counts as eight
	assign add_bytes = (!last_word || valid_bytes[3]) ? 4'd8 : valid_bytes;

	// Marker word: valid bytes of the last word, then 0x80 (alone if full)
	assign mark_sh = {3'd7 - vb_q, 3'b000};
	always_comb begin
		if (full_q) begin
			mark_word = {8'h80, 56'd0};
		end else begin
			mark_word = (word_q & ~({WORD_W{1'b1}} >> {vb_q, 3'b000}))
				| ({56'd0, 8'h80} << mark_sh);
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_WORD: push_word = word_q;
			SEL_MARK: push_word = mark_word;
			SEL_ZERO: push_word = '0;
			SEL_LEN:  push_word = {total_q, 3'b000};
			default:  push_word = '0;
		endcase
	end

	// One round of the compression and the message schedule
	assign s0   = {w_q[1][0], w_q[1][63:1]} ^ {w_q[1][7:0], w_q[1][63:8]} ^ (w_q[1] >> 7);
	assign s1   = {w_q[14][18:0], w_q[14][63:19]} ^ {w_q[14][60:0], w_q[14][63:61]}
		^ (w_q[14] >> 6);
	assign new_w = w_q[0] + s0 + w_q[9] + s1;
	assign big0 = {v_q[0][27:0], v_q[0][63:28]} ^ {v_q[0][33:0], v_q[0][63:34]}
		^ {v_q[0][38:0], v_q[0][63:39]};
	assign big1 = {v_q[4][13:0], v_q[4][63:14]} ^ {v_q[4][17:0], v_q[4][63:18]}
		^ {v_q[4][40:0], v_q[4][63:41]};
	assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1   = v_q[7] + big1 + ch + KTAB[cmd.rnd] + w_q[0];
	assign t2   = big0 + maj;

	// Latched transaction payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			word_q <= message_word;
			vb_q   <= valid_bytes[2:0];
			full_q <= valid_bytes[3];
		end
	end

	// Schedule shift line: words enter at the top, rounds feed it back
	always_ff @(posedge clk) begin
		if (cmd.push || cmd.round) begin
			for (int i = 0; i < BLK_W - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLK_W-1] <= cmd.push ? push_word : new_w;
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < HASH_N; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Hash state and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_N; i++) begin
				h_q[i] <= IV[i];
			end
			total_q <= '0;
		end else begin
			if (cmd.finish) begin
				for (int i = 0; i < HASH_N; i++) begin
					h_q[i] <= IV[i];
				end
				total_q <= '0;
			end else begin
				if (cmd.add) begin
					for (int i = 0; i < HASH_N; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
				if (cmd.accept) begin
					total_q <= total_q + {{(TOTAL_W-4){1'b0}}, add_bytes};
				end
			end
		end
	end

	assign digest_word = h_q[cmd.oidx];

endmodule

>>> hw/rtl/sha512he_ctrl.sv
module sha512he_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_ready,
	input  logic                  last_word,
	input  logic                  full_word,
	output logic                  dig_valid,
	output logic                  dig_last,
	input  logic                  dig_ready,
	output sha512he_pkg::dp_cmd_t cmd
);
	import sha512he_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PUSH  = 5'b00010,
		S_ROUND = 5'b00100,
		S_ADD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t     state_q;
	logic [3:0] pos_q;
	logic [6:0] rnd_q;
	logic [2:0] oidx_q;
	logic       last_q, need_word_q, need_mark_q, wrap_q, len_done_q;
	push_sel_t  sel;

	// Next schedule word: message word, marker, zero pad or length
	always_comb begin
		if (need_word_q) begin
			sel = SEL_WORD;
		end else if (need_mark_q) begin
			sel = SEL_MARK;
		end else if (wrap_q || pos_q != 4'd15) begin
			sel = SEL_ZERO;
		end else begin
			sel = SEL_LEN;
		end
	end

	// Commands to the datapath
	always_comb begin
		cmd        = '0;
		cmd.sel    = sel;
		cmd.rnd    = rnd_q;
		cmd.oidx   = oidx_q;
		cmd.accept = (state_q == S_IDLE) && msg_valid;
		cmd.push   = (state_q == S_PUSH);
		cmd.start  = (state_q == S_PUSH) && (pos_q == 4'd15);
		cmd.round  = (state_q == S_ROUND);
		cmd.add    = (state_q == S_ADD);
		cmd.finish = (state_q == S_OUT) && dig_ready && (oidx_q == 3'd7);
	end

	assign msg_ready = (state_q == S_IDLE);
	assign dig_valid = (state_q == S_OUT);
	assign dig_last  = (oidx_q == 3'd7);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			rnd_q       <= '0;
			oidx_q      <= '0;
			last_q      <= 1'b0;
			need_word_q <= 1'b0;
			need_mark_q <= 1'b0;
			wrap_q      <= 1'b0;
			len_done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (msg_valid) begin
						last_q      <= last_word;
						need_word_q <= !last_word || full_word;
						need_mark_q <= last_word;
						wrap_q      <= 1'b0;
						len_done_q  <= 1'b0;
						state_q     <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (need_word_q) begin
						need_word_q <= 1'b0;
					end else if (need_mark_q) begin
						need_mark_q <= 1'b0;
						wrap_q      <= (pos_q == 4'd14);
					end else if (wrap_q) begin
						if (pos_q == 4'd15) begin
							wrap_q <= 1'b0;
						end
					end else if (pos_q == 4'd15) begin
						len_done_q <= 1'b1;
					end
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'd15) begin
						rnd_q   <= '0;
						state_q <= S_ROUND;
					end else if (!last_q) begin
						state_q <= S_IDLE;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(ROUNDS - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					if (last_q && len_done_q) begin
						oidx_q  <= '0;
						state_q <= S_OUT;
					end else if (last_q) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (dig_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							last_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "sha512_hash_engine_top_macros.svh"

	`SHA_CHECK(a_no_overlap, !(msg_ready && dig_valid), "input taken while digest pending")
	`SHA_CHECK(a_rnd_range, (state_q != S_ROUND) || (rnd_q < 7'(ROUNDS)), "round index out of range")
	`SHA_NEXT(a_digest_done, cmd.finish, state_q == S_IDLE && pos_q == 4'd0, "bad state after digest")
	`SHA_NEXT(a_len_block, cmd.start && sel == SEL_LEN, len_done_q, "length word not recorded")

endmodule

>>> hw/rtl/sha512_hash_engine_top.sv
// SHA-512 engine. Message words (big-endian, 64 bits) arrive on msg; the word flagged
// last_word may carry 0 to 8 valid leading bytes, any other word is always taken as 8.
// After the last word the eight digest words leave on digest, most significant first,
// the eighth flagged digest_last, and the engine starts a fresh message. One word
// is taken at a time: each is accepted and then shifted into the 16-word schedule
// line, and every 16th word starts the compression, which runs one round per cycle
// through a single round unit, followed by the hash update. Padding pushes one word
// per cycle and may need a second compression. No new message word is taken while
// the digest is being read out.
module sha512_hash_engine_top (
	input logic           clk,
	input logic           arst_n,
	sha512he_msg_if.sink  msg,
	sha512he_dig_if.source digest
);
	import sha512he_pkg::*;

	dp_cmd_t cmd;

	// Sequencer
	sha512he_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg.valid),
		.msg_ready (msg.ready),
		.last_word (msg.last_word),
		.full_word (msg.valid_bytes[3]),
		.dig_valid (digest.valid),
		.dig_last  (digest.digest_last),
		.dig_ready (digest.ready),
		.cmd       (cmd)
	);

	// Schedule, rounds and hash state
	sha512he_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_word (msg.message_word),
		.valid_bytes  (msg.valid_bytes),
		.last_word    (msg.last_word),
		.digest_word  (digest.digest_word)
	);

endmodule

>>> sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sha512he_pkg::*;

	// Traffic shapes for the run phases
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [63:0] word;
		logic        last;
	} digest_exp_t;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
		logic        typed;
		logic [63:0] first_digest;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sha512he_msg_if msg_ch ();
	sha512he_dig_if dig_ch ();

	sha512_hash_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	always #10 clk = ~clk;

	// Predictor state
	word_t       hv [8];
	word_t       sched [16];
	int unsigned slot;
	logic [60:0] nbytes_total;

	digest_exp_t digest_q [$];
	idle_mode_t  mode = IDLE_NONE;
	int          errors = 0;
	int          words_sent = 0;
	int          digests_seen = 0;
	int          hold_req = 0;
	int          idle_cycles = 0;
	bit          timed_out = 0;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// One 80-round compression folded into the hash state
	function automatic void compress();
		word_t v [8];
		word_t wi, w15, w2, w7, s0, s1, b0, b1, ch, mj, t1, t2;
		for (int j = 0; j < 8; j++) v[j] = hv[j];
		for (int r = 0; r < 80; r++) begin
			wi  = sched[r & 15];
			w15 = sched[(r + 1) & 15];
			w2  = sched[(r + 14) & 15];
			w7  = sched[(r + 9) & 15];
			s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
			s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
			b0  = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
			b1  = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
			ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
			mj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1  = v[7] + b1 + ch + KTAB[r] + wi;
			t2  = b0 + mj;
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			sched[r & 15] = wi + s0 + w7 + s1;
		end
		for (int j = 0; j < 8; j++) hv[j] += v[j];
	endfunction

	function automatic void absorb_word(word_t w);
		sched[slot] = w;
		slot++;
		if (slot == 16) begin
			compress();
			slot = 0;
		end
	endfunction

	function automatic void hash_reset();
		for (int j = 0; j < 8; j++) hv[j] = IV[j];
		for (int j = 0; j < 16; j++) sched[j] = '0;
		slot = 0;
		nbytes_total = '0;
	endfunction

	// Advance the predictor by one accepted word; queue the digest on a last word
	function automatic void hash_word(word_t w, logic [3:0] nb, logic last);
		int unsigned n;
		word_t pad;
		if (!last) begin
			nbytes_total += 61'd8;
			absorb_word(w);
			return;
		end
		n = (nb > 8) ? 8 : nb;
		nbytes_total += 61'(n);
		if (n == 8) begin
			absorb_word(w);
			pad = 64'h80 << 56;
		end else begin
			pad = (n == 0) ? '0 : (w & ({64{1'b1}} << (64 - 8 * n)));
			pad |= 64'h80 << (56 - 8 * n);
		end
		sched[slot] = pad;
		slot++;
		if (slot > 14) begin
			for (int j = slot; j < 16; j++) sched[j] = '0;
			compress();
			slot = 0;
		end
		for (int j = slot; j < 15; j++) sched[j] = '0;
		sched[15] = {nbytes_total, 3'b000};
		compress();
		for (int j = 0; j < 8; j++) digest_q.push_back('{hv[j], j == 7});
		hash_reset();
	endfunction

	task automatic report(string what, word_t got, word_t want);
		errors++;
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// Offer one word, with sender idling per mode
	task automatic send_word(word_t w, logic [3:0] nb, logic last);
		if ((mode == IDLE_SEND || mode == IDLE_BOTH) && $urandom_range(99) < 52) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		msg_ch.valid        <= 1'b1;
		msg_ch.message_word <= w;
		msg_ch.valid_bytes  <= nb;
		msg_ch.last_word    <= last;
		do @(posedge clk); while (!msg_ch.ready);
		hash_word(w, nb, last);
		words_sent++;
	endtask

	task automatic release_bus();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for all digests, then for the engine to settle
	task automatic drain();
		release_bus();
		while (digest_q.size() != 0 && !timed_out) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_message();
		int unsigned len;
		logic [3:0] nb;
		len = ($urandom_range(9) == 0) ? $urandom_range(16, 33) : $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			// non-last words sometimes carry a random byte count that must be ignored
			nb = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
			send_word({$urandom, $urandom}, nb, 1'b0);
		end
		send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
	endtask

	// Receiver: random stalls, plus long hold-offs on request
	int hold_seen = 0;
	int hold_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= 600;
			dig_ch.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			dig_ch.ready <= 1'b0;
		end else if (mode == IDLE_RECV || mode == IDLE_BOTH) begin
			dig_ch.ready <= ($urandom_range(99) >= 52);
		end else begin
			dig_ch.ready <= 1'b1;
		end
	end

	// Digest checker
	always @(posedge clk) begin
		digest_exp_t e;
		if (arst_n && dig_ch.valid && dig_ch.ready) begin
			digests_seen++;
			if (digest_q.size() == 0) begin
				report("unexpected digest word", dig_ch.digest_word, '0);
			end else begin
				e = digest_q.pop_front();
				if (dig_ch.digest_word !== e.word)
					report("digest_word", dig_ch.digest_word, e.word);
				if (dig_ch.digest_last !== e.last)
					report("digest_last", 64'(dig_ch.digest_last), 64'(e.last));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			timed_out = 1;
			$display("simulation failed");
			$finish;
		end
	end

	stim_row_t rows [$];

	initial begin
		msg_ch.valid        <= 1'b0;
		msg_ch.message_word <= '0;
		msg_ch.valid_bytes  <= '0;
		msg_ch.last_word    <= 1'b0;
		hash_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty message, "abc", byte counts, extra-block padding
		rows.push_back('{64'h0, 4'd0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd});
		rows.push_back('{64'h6162630000000000, 4'd3, 1'b1, 1'b1, 64'hddaf35a193617aba});
		rows.push_back('{64'hffffffffffffffff, 4'd8, 1'b1, 1'b0, 64'h0});
		rows.push_back('{64'hffffffffffffffff, 4'd15, 1'b1, 1'b0, 64'h0});
		rows.push_back('{64'h0123456789abcdef, 4'd2, 1'b0, 1'b0, 64'h0});
		rows.push_back('{64'hffffffffffffffff, 4'd7, 1'b1, 1'b0, 64'h0});
		for (int i = 0; i < 14; i++)
			rows.push_back('{(i % 2) ? 64'hffffffffffffffff : 64'h0, 4'd0, 1'b0, 1'b0, 64'h0});
		rows.push_back('{64'hfedcba9876543210, 4'd1, 1'b1, 1'b0, 64'h0});
		foreach (rows[i]) begin
			if (rows[i].typed && rows[i].last) begin
				send_word(rows[i].word, rows[i].nbytes, rows[i].last);
				if (digest_q[digest_q.size() - 8].word !== rows[i].first_digest)
					report("known digest", digest_q[digest_q.size() - 8].word,
						rows[i].first_digest);
			end else begin
				send_word(rows[i].word, rows[i].nbytes, rows[i].last);
			end
		end
		// Fifteen full words plus a full last word: block closes before the pad mark
		for (int i = 0; i < 15; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
		send_word({$urandom, $urandom}, 4'd8, 1'b1);
		drain();

		// Random messages over the traffic phases
		for (int p = 0; p < 4; p++) begin
			mode = idle_mode_t'(p);
			for (int m = 0; m < 3; m++) random_message();
			if (p == 0) begin
				// Long receiver hold-off while words keep coming
				hold_req++;
				for (int m = 0; m < 2; m++) random_message();
			end
			// sender pauses until every digest is back
			drain();
		end

		$display("covered %0d message words, %0d digest words checked", words_sent,
			digests_seen);
		$display("idle phases, long receiver hold-off, padding with an extra block");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sha512he_pkg.sv
hw/rtl/sha512he_if.sv
hw/rtl/sha512he_dp.sv
hw/rtl/sha512he_ctrl.sv
hw/rtl/sha512_hash_engine_top.sv
sim/tb.sv
